/* hw/rtl/hscw_pkg.sv */
// Shared types, constants and codes for the segment cutter and live window.
`timescale 1ns / 1ps
package hscw_pkg;

  localparam int MAX_PIECES_DEF = 1024;
  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [23:0] TARGET_MS_RST  = 24'd6000;
  localparam logic [23:0] MIN_MS_RST     = 24'd3000;
  localparam logic [23:0] MAX_MS_RST     = 24'd12000;
  localparam logic [31:0] SEG_BYTES_RST  = 32'd8388608;
  localparam logic [4:0]  WIN_COUNT_RST  = 5'd6;
  localparam logic [39:0] WIN_BYTES_RST  = 40'd67108864;
  localparam logic [23:0] TARGET_MS_DEF  = 24'd6000;
  localparam logic [4:0]  WIN_COUNT_DEF  = 5'd6;

  // floor(2^37 / 45): x / 45 for 32-bit x, low by at most one
  localparam logic [31:0] DIV45_MAGIC    = 32'd3054198966;
  localparam int          DIV45_SHIFT    = 37;
  localparam logic [6:0]  TICKS_PER_MS   = 7'd90;

  localparam logic [1:0] OP_SLICE  = 2'd0;
  localparam logic [1:0] OP_DISC   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_WAIT_KEY = 2'd1;
  localparam logic [1:0] ST_CEILING  = 2'd2;
  localparam logic [1:0] ST_COMMAND  = 2'd3;

  localparam logic [2:0] CFG_TARGET_MS   = 3'd0;
  localparam logic [2:0] CFG_MIN_MS      = 3'd1;
  localparam logic [2:0] CFG_MAX_MS      = 3'd2;
  localparam logic [2:0] CFG_SEG_BYTES   = 3'd3;
  localparam logic [2:0] CFG_WIN_COUNT   = 3'd4;
  localparam logic [2:0] CFG_WIN_BYTES   = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic        is_video;
    logic        is_key;
    logic [32:0] dts;
    logic [23:0] slice_bytes;
    logic [11:0] psi_bytes;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic [1:0]  status;
    logic        cut_made;
    logic        cut_forced;
    logic [31:0] seg_number;
    logic [26:0] seg_ms;
    logic [31:0] seg_size;
    logic        seg_disc;
    logic [4:0]  evicted;
    logic [31:0] media_seq;
    logic [31:0] disc_seq;
    logic [4:0]  window_len;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CHECK, S_CEIL, S_ADD, S_BYTES,
    S_CMD_END, S_DIV, S_EVICT, S_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       set_status;
    logic [1:0] status;
    logic       start_seg;
    logic       cut;
    logic       cut_forced;
    logic       restart;
    logic       clr_started;
    logic       add;
    logic       set_disc;
    logic       div;
    logic       pop;
    logic       publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       started;
    logic       vkey;
    logic       cut_ok;
    logic       cond_key;
    logic       cond_max;
    logic       at_ceiling;
    logic       over_bytes;
    logic       evict_need;
    logic       out_empty;
  } dp_stat_t;

endpackage

/* hw/rtl/hscw_ctrl.sv */
// Sequencer for one item: start, cut checks, byte add, cut/divide/evict, publish.
`timescale 1ns / 1ps
module hscw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output hscw_pkg::ctrl_cmd_t cmd,
  input  hscw_pkg::dp_stat_t  stat
);
  import hscw_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.op == OP_SLICE) begin
          if (!stat.started && !stat.vkey) state_next = S_FINISH;
          else state_next = S_CHECK;
        end else if (stat.op == OP_DISC || stat.op == OP_FINISH) begin
          if (stat.cut_ok) begin
            state_next = S_DIV;
            ret_next   = S_CMD_END;
          end else begin
            state_next = S_CMD_END;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CHECK: begin
        if ((stat.cond_key || stat.cond_max) && stat.cut_ok) begin
          state_next = S_DIV;
          ret_next   = S_CEIL;
        end else begin
          state_next = S_CEIL;
        end
      end
      S_CEIL: begin
        if (stat.at_ceiling) begin
          if (stat.cut_ok) begin
            state_next = S_DIV;
            ret_next   = S_FINISH;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          state_next = S_ADD;
        end
      end
      S_ADD: state_next = S_BYTES;
      S_BYTES: begin
        if (stat.over_bytes && stat.cut_ok) begin
          state_next = S_DIV;
          ret_next   = S_FINISH;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CMD_END: state_next = S_FINISH;
      S_DIV:     state_next = S_EVICT;
      S_EVICT: begin
        if (!stat.evict_need) state_next = ret;
      end
      S_FINISH: begin
        if (stat.out_empty) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_DECODE: begin
        cmd.set_status = 1'b1;
        if (stat.op == OP_SLICE) begin
          if (!stat.started && !stat.vkey) begin
            cmd.status = ST_WAIT_KEY;
          end else begin
            cmd.status    = ST_ACCEPTED;
            cmd.start_seg = !stat.started;
          end
        end else begin
          cmd.status = ST_COMMAND;
          cmd.cut    = (stat.op == OP_DISC || stat.op == OP_FINISH) && stat.cut_ok;
        end
      end
      S_CHECK: begin
        if (stat.cond_key || stat.cond_max) begin
          cmd.cut        = stat.cut_ok;
          cmd.cut_forced = !stat.cond_key;
          cmd.restart    = 1'b1;
        end
      end
      S_CEIL: begin
        if (stat.at_ceiling) begin
          cmd.cut         = stat.cut_ok;
          cmd.cut_forced  = 1'b1;
          cmd.clr_started = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status      = ST_CEILING;
        end
      end
      S_ADD: cmd.add = 1'b1;
      S_BYTES: begin
        if (stat.over_bytes) begin
          cmd.cut         = stat.cut_ok;
          cmd.cut_forced  = 1'b1;
          cmd.clr_started = 1'b1;
        end
      end
      S_CMD_END: cmd.set_disc = (stat.op == OP_DISC);
      S_DIV:     cmd.div = 1'b1;
      S_EVICT:   cmd.pop = stat.evict_need;
      S_FINISH:  cmd.publish = stat.out_empty;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/hscw_datapath.sv */
// Segment state, window ring, cut records, divide by 90 and the output buffer.
`timescale 1ns / 1ps
module hscw_datapath #(
  parameter int MAX_PIECES = hscw_pkg::MAX_PIECES_DEF,
  parameter int MAX_WINDOW = hscw_pkg::MAX_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hscw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hscw_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [39:0]         cfg_data,
  input  hscw_pkg::ctrl_cmd_t cmd,
  output hscw_pkg::dp_stat_t  stat
);
  import hscw_pkg::*;

  localparam int RING_DEPTH = MAX_WINDOW + 1;
  localparam int HW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int PW = $clog2(MAX_PIECES + 1);

  // configuration
  logic [23:0] target_ms, min_ms, max_ms;
  logic [31:0] seg_byte_limit;
  logic [4:0]  window_count;
  logic [39:0] window_byte_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_ms         <= TARGET_MS_RST;
      min_ms            <= MIN_MS_RST;
      max_ms            <= MAX_MS_RST;
      seg_byte_limit    <= SEG_BYTES_RST;
      window_count      <= WIN_COUNT_RST;
      window_byte_limit <= WIN_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_MS: target_ms         <= cfg_data[23:0];
        CFG_MIN_MS:    min_ms            <= cfg_data[23:0];
        CFG_MAX_MS:    max_ms            <= cfg_data[23:0];
        CFG_SEG_BYTES: seg_byte_limit    <= cfg_data[31:0];
        CFG_WIN_COUNT: window_count      <= cfg_data[4:0];
        CFG_WIN_BYTES: window_byte_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective limits, in 90 kHz ticks so no divide is needed to compare
  logic [23:0] tgt_eff, mn_eff;
  logic [24:0] mx_eff;
  logic [30:0] thr_min;
  logic [31:0] thr_max;
  logic [4:0]  wc_raw;
  logic [CW-1:0] wc_eff;

  always_comb begin
    tgt_eff = (target_ms == '0) ? TARGET_MS_DEF : target_ms;
    mn_eff  = (min_ms > tgt_eff) ? tgt_eff : min_ms;
    mx_eff  = (max_ms < tgt_eff) ? {tgt_eff, 1'b0} : {1'b0, max_ms};
    wc_raw  = (window_count == '0) ? WIN_COUNT_DEF : window_count;
    wc_eff  = (32'(wc_raw) > 32'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(wc_raw);
  end

  always_ff @(posedge clk) begin
    thr_min <= 31'(31'(mn_eff) * 31'(TICKS_PER_MS));
    thr_max <= 32'(mx_eff) * 32'(TICKS_PER_MS);
  end

  // item and open segment
  in_item_t        item;
  logic            started, disc_pending;
  logic [32:0]     seg_start_dts, seg_end_dts;
  logic [PW-1:0]   pieces;
  logic [31:0]     open_bytes, next_seq, disc_count;
  logic [31:0]     ring_bytes [RING_DEPTH];
  logic            ring_disc  [RING_DEPTH];
  logic [HW-1:0]   head;
  logic [CW-1:0]   count;
  logic [40:0]     kept;
  logic [1:0]      status_q;

  logic [31:0] rec_seq [2];
  logic [26:0] rec_ms [2];
  logic [31:0] rec_size [2];
  logic        rec_disc [2];
  logic        rec_forced [2];
  logic [4:0]  rec_evicted [2];
  logic [1:0]  ncuts;
  logic        cur;

  logic [31:0] div_x;
  logic [63:0] div_prod;

  logic          vkey, add_psi, evict_need;
  logic [32:0]   diff;
  logic [33:0]   byte_sum;
  logic [CW:0]   tail_sum;
  logic [HW-1:0] tail, head_inc;
  logic [26:0]   q0;
  logic [31:0]   rem;

  always_comb begin
    vkey     = item.is_video & item.is_key;
    diff     = seg_end_dts - seg_start_dts;
    add_psi  = (pieces == '0) && (item.psi_bytes != '0);
    byte_sum = 34'(open_bytes) + 34'(add_psi ? item.psi_bytes : 12'd0)
             + 34'(item.slice_bytes);
    tail_sum = (CW + 1)'(head) + (CW + 1)'(count);
    if (32'(tail_sum) >= RING_DEPTH) tail = HW'(32'(tail_sum) - RING_DEPTH);
    else tail = HW'(tail_sum);
    head_inc = (32'(head) == RING_DEPTH - 1) ? '0 : HW'(head + 1'b1);
    evict_need = (count != '0) &&
                 ((count > wc_eff) ||
                  (window_byte_limit != '0 && kept > 41'(window_byte_limit)));
    q0  = div_prod[DIV45_SHIFT +: 27];
    rem = div_x - 32'(q0) * 32'd45;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      disc_pending  <= 1'b0;
      seg_start_dts <= '0;
      seg_end_dts   <= '0;
      pieces        <= '0;
      open_bytes    <= '0;
      next_seq      <= '0;
      disc_count    <= '0;
      head          <= '0;
      count         <= '0;
      kept          <= '0;
      ncuts         <= '0;
      cur           <= 1'b0;
      status_q      <= ST_ACCEPTED;
    end else begin
      if (cmd.load) begin
        item  <= in_data;
        ncuts <= '0;
      end
      if (cmd.set_status) status_q <= cmd.status;
      if (cmd.start_seg) begin
        started       <= 1'b1;
        seg_start_dts <= item.dts;
        seg_end_dts   <= item.dts;
      end
      if (cmd.cut) begin
        rec_seq[ncuts[0]]     <= next_seq;
        rec_size[ncuts[0]]    <= open_bytes;
        rec_disc[ncuts[0]]    <= disc_pending;
        rec_forced[ncuts[0]]  <= cmd.cut_forced;
        rec_evicted[ncuts[0]] <= '0;
        cur          <= ncuts[0];
        ncuts        <= ncuts + 2'd1;
        next_seq     <= next_seq + 32'd1;
        disc_pending <= 1'b0;
        div_x        <= diff[32:1];
        div_prod     <= 64'(diff[32:1]) * 64'(DIV45_MAGIC);
        if (32'(count) < RING_DEPTH) begin
          ring_bytes[tail] <= open_bytes;
          ring_disc[tail]  <= disc_pending;
          count <= count + 1'b1;
          kept  <= kept + 41'(open_bytes);
        end
        pieces        <= '0;
        open_bytes    <= '0;
        seg_start_dts <= '0;
        seg_end_dts   <= '0;
      end
      if (cmd.restart) begin
        started       <= 1'b1;
        seg_start_dts <= item.dts;
        seg_end_dts   <= item.dts;
      end
      if (cmd.clr_started) started <= 1'b0;
      if (cmd.add) begin
        open_bytes  <= byte_sum[33:32] != 2'b00 ? 32'hFFFF_FFFF : byte_sum[31:0];
        pieces      <= pieces + (add_psi ? PW'(2) : PW'(1));
        seg_end_dts <= item.dts;
      end
      if (cmd.set_disc) begin
        disc_pending <= 1'b1;
        started      <= 1'b0;
      end
      if (cmd.div) rec_ms[cur] <= (rem >= 32'd45) ? q0 + 27'd1 : q0;
      if (cmd.pop) begin
        if (ring_disc[head]) disc_count <= disc_count + 32'd1;
        kept             <= kept - 41'(ring_bytes[head]);
        head             <= head_inc;
        count            <= count - 1'b1;
        rec_evicted[cur] <= rec_evicted[cur] + 5'd1;
      end
    end
  end

  always_comb begin
    stat.op         = item.op;
    stat.started    = started;
    stat.vkey       = vkey;
    stat.cut_ok     = (pieces != '0) && (ncuts < 2'd2);
    stat.cond_key   = (pieces != '0) && vkey && (diff >= 33'(thr_min));
    stat.cond_max   = (pieces != '0) && (diff >= 33'(thr_max));
    stat.at_ceiling = (32'(pieces) >= MAX_PIECES);
    stat.over_bytes = (open_bytes > seg_byte_limit);
    stat.evict_need = evict_need;
    stat.out_empty  = !out_valid;
  end

  // output buffer: holds a finished item's results while the next one works
  logic [31:0] ob_seq [2];
  logic [26:0] ob_ms [2];
  logic [31:0] ob_size [2];
  logic        ob_disc [2];
  logic        ob_forced [2];
  logic [4:0]  ob_evicted [2];
  logic [1:0]  ob_ncuts;
  logic [1:0]  ob_status;
  logic [31:0] ob_mseq, ob_dseq;
  logic [4:0]  ob_wlen;
  logic        ob_rd;
  logic        ob_last;

  assign ob_last = (ob_ncuts <= 2'd1) || ob_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ob_rd     <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
        ob_rd     <= 1'b0;
      end else if (out_valid && !out_stall) begin
        if (ob_last) out_valid <= 1'b0;
        else ob_rd <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      for (int k = 0; k < 2; k++) begin
        ob_seq[k]     <= rec_seq[k];
        ob_ms[k]      <= rec_ms[k];
        ob_size[k]    <= rec_size[k];
        ob_disc[k]    <= rec_disc[k];
        ob_forced[k]  <= rec_forced[k];
        ob_evicted[k] <= rec_evicted[k];
      end
      ob_ncuts  <= ncuts;
      ob_status <= status_q;
      ob_mseq   <= (count != '0) ? next_seq - 32'(count) : 32'd0;
      ob_dseq   <= disc_count;
      ob_wlen   <= 5'(count);
    end
  end

  always_comb begin
    out_data            = '0;
    out_data.last       = ob_last;
    out_data.status     = ob_status;
    out_data.media_seq  = ob_mseq;
    out_data.disc_seq   = ob_dseq;
    out_data.window_len = ob_wlen;
    if (ob_ncuts != '0) begin
      out_data.cut_made   = 1'b1;
      out_data.cut_forced = ob_forced[ob_rd];
      out_data.seg_number = ob_seq[ob_rd];
      out_data.seg_ms     = ob_ms[ob_rd];
      out_data.seg_size   = ob_size[ob_rd];
      out_data.seg_disc   = ob_disc[ob_rd];
      out_data.evicted    = ob_evicted[ob_rd];
    end
  end

endmodule

/* hw/rtl/hls_segment_cut_and_window.sv */
// Top level: live segment cutter with sliding window, controller plus datapath.
`timescale 1ns / 1ps
// Takes media slices, discontinuity and finish commands one at a time and
// returns one result per finished segment (at most two) or a single status
// result. Slices waiting for a keyframe and unused ops take the shortest
// path through the sequencer and accepted slices the longest. Each cut adds
// the divide-by-90 of the duration, the window check and one eviction step
// per window entry evicted, all run by one sequencer over a shared datapath.
// Results sit in an output buffer, so the next item is taken while they
// drain; the item after that waits only if the buffer is still full at its
// end. Configuration writes are registered; the minimum and maximum
// durations also pass through registered tick thresholds.
module hls_segment_cut_and_window #(
  parameter int MAX_PIECES = hscw_pkg::MAX_PIECES_DEF,
  parameter int MAX_WINDOW = hscw_pkg::MAX_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hscw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hscw_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [39:0]         cfg_data
);
  import hscw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  hscw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  hscw_datapath #(
    .MAX_PIECES (MAX_PIECES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* test/hls_segment_cut_and_window_tb.sv */
// Testbench for the segment cutter with sliding window: directed and random slices.
`timescale 1ns / 1ps
module hls_segment_cut_and_window_tb;
  import hscw_pkg::*;

  localparam int PIECE_CEIL = 1024;
  localparam int WIN_MAX = 16;
  localparam int RING_N = WIN_MAX + 1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [39:0] cfg_data = '0;

  hls_segment_cut_and_window dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block's state and registers
  logic [23:0] r_target, r_min, r_max;
  logic [31:0] r_seg_bytes;
  logic [4:0] r_win_count;
  logic [39:0] r_win_bytes;
  logic seg_open, disc_mark;
  logic [32:0] seg_start_dts, seg_end_dts;
  int unsigned pieces;
  logic [31:0] seg_bytes, seq_next, disc_total;
  logic [31:0] ring_size[RING_N];
  logic ring_mark[RING_N];
  int unsigned head, count;
  logic [40:0] kept;

  out_item_t cuts_q[$];
  out_item_t expected_q[$];
  int errors = 0;
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  int quiet_cycles = 0;

  function automatic logic [26:0] open_duration();
    logic [32:0] d;
    d = seg_end_dts - seg_start_dts;
    return 27'(d / 90);
  endfunction

  task automatic close_segment(input logic forced);
    out_item_t r;
    int unsigned wc;
    if (pieces == 0 || cuts_q.size() >= 2) return;
    r = '0;
    r.cut_made = 1'b1;
    r.cut_forced = forced;
    r.seg_number = seq_next;
    seq_next++;
    r.seg_ms = open_duration();
    r.seg_size = seg_bytes;
    r.seg_disc = disc_mark;
    if (count < RING_N) begin
      ring_size[(head + count) % RING_N] = seg_bytes;
      ring_mark[(head + count) % RING_N] = disc_mark;
      count++;
      kept += 41'(seg_bytes);
    end
    disc_mark = 1'b0;
    wc = (r_win_count == 0) ? 6 : r_win_count;
    if (wc > WIN_MAX) wc = WIN_MAX;
    while (count > 0 && (count > wc || (r_win_bytes != 0 && kept > r_win_bytes))) begin
      if (ring_mark[head]) disc_total++;
      kept -= 41'(ring_size[head]);
      head = (head + 1) % RING_N;
      count--;
      r.evicted++;
    end
    cuts_q.push_back(r);
    pieces = 0;
    seg_bytes = 0;
    seg_start_dts = 0;
    seg_end_dts = 0;
  endtask

  task automatic add_piece(input logic [31:0] n);
    logic [32:0] s;
    s = {1'b0, seg_bytes} + {1'b0, n};
    seg_bytes = s[32] ? 32'hFFFF_FFFF : s[31:0];
    pieces++;
  endtask

  task automatic predict_slice(input in_item_t it, output logic [1:0] st);
    logic [23:0] tgt, mn;
    logic [24:0] mx;
    logic vkey;
    logic [26:0] dur;
    tgt = (r_target == 0) ? TARGET_MS_DEF : r_target;
    mn = (r_min > tgt) ? tgt : r_min;
    mx = (r_max < tgt) ? {tgt, 1'b0} : {1'b0, r_max};
    vkey = it.is_video && it.is_key;
    st = ST_ACCEPTED;
    if (!seg_open) begin
      if (!vkey) begin
        st = ST_WAIT_KEY;
        return;
      end
      seg_open = 1'b1;
      seg_start_dts = it.dts;
      seg_end_dts = it.dts;
    end
    dur = open_duration();
    if (pieces > 0 && vkey && dur >= mn) begin
      close_segment(1'b0);
      seg_start_dts = it.dts;
      seg_end_dts = it.dts;
    end else if (pieces > 0 && dur >= mx) begin
      close_segment(1'b1);
      seg_start_dts = it.dts;
      seg_end_dts = it.dts;
    end
    if (pieces >= PIECE_CEIL) begin
      close_segment(1'b1);
      seg_open = 1'b0;
      st = ST_CEILING;
      return;
    end
    if (pieces == 0 && it.psi_bytes > 0) add_piece(32'(it.psi_bytes));
    add_piece(32'(it.slice_bytes));
    seg_end_dts = it.dts;
    if (seg_bytes > r_seg_bytes) begin
      close_segment(1'b1);
      seg_open = 1'b0;
    end
  endtask

  task automatic predict_segments(input in_item_t it);
    logic [1:0] st;
    out_item_t r;
    int n;
    cuts_q.delete();
    if (it.op == OP_SLICE) predict_slice(it, st);
    else begin
      st = ST_COMMAND;
      if (it.op == OP_DISC) begin
        close_segment(1'b0);
        disc_mark = 1'b1;
        seg_open = 1'b0;
      end else if (it.op == OP_FINISH) close_segment(1'b0);
    end
    if (cuts_q.size() == 0) cuts_q.push_back('0);
    n = cuts_q.size();
    for (int k = 0; k < n; k++) begin
      r = cuts_q[k];
      r.last = (k == n - 1);
      r.status = st;
      r.media_seq = (count != 0) ? seq_next - count : 32'd0;
      r.disc_seq = disc_total;
      r.window_len = 5'(count);
      expected_q.push_back(r);
    end
  endtask

  // valid stays up after a transfer only when the next item follows at once
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_in_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_segments(it);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < WATCHDOG_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TARGET_MS: r_target = val[23:0];
      CFG_MIN_MS:    r_min = val[23:0];
      CFG_MAX_MS:    r_max = val[23:0];
      CFG_SEG_BYTES: r_seg_bytes = val[31:0];
      CFG_WIN_COUNT: r_win_count = val[4:0];
      CFG_WIN_BYTES: r_win_bytes = val;
      default: ;
    endcase
    repeat (3) @(posedge clk);
  endtask

  function automatic in_item_t slice_item(input logic v, input logic k, input logic [32:0] d,
                                          input logic [23:0] b, input logic [11:0] p);
    in_item_t it;
    it.op = OP_SLICE;
    it.is_video = v;
    it.is_key = k;
    it.dts = d;
    it.slice_bytes = b;
    it.psi_bytes = p;
    return it;
  endfunction

  function automatic in_item_t cmd_item(input logic [1:0] op);
    in_item_t it;
    it = '0;
    it.op = op;
    it.dts = 33'({$urandom, $urandom});
    it.is_video = 1'($urandom);
    it.is_key = 1'($urandom);
    return it;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual %p", $realtime, out_data);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_data !== e) begin
            $display("%0t mismatch: expected %p, actual %p", $realtime, e, out_data);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_out_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed();
    logic [32:0] d;
    send_item(slice_item(1'b1, 1'b0, 33'd100, 24'd10, 12'd5));       // waits for key
    send_item(slice_item(1'b0, 1'b1, 33'd100, 24'd10, 12'd5));
    send_item(slice_item(1'b1, 1'b1, 33'h1_FFFF_FF00, 24'hFFFFFF, 12'hFFF));
    send_item(slice_item(1'b0, 1'b0, 33'h1_FFFF_FFFF, 24'd0, 12'd0));
    send_item(slice_item(1'b1, 1'b1, 33'd400000, 24'd1, 12'd0));     // key cut across wrap
    send_item(slice_item(1'b1, 1'b0, 33'd2000000, 24'd7, 12'd3));    // forced by max
    send_item(cmd_item(OP_DISC));
    send_item(cmd_item(OP_DISC));
    send_item(slice_item(1'b1, 1'b1, 33'd0, 24'd5, 12'd0));
    send_item(cmd_item(OP_FINISH));
    send_item(slice_item(1'b0, 1'b1, 33'd90, 24'd5, 12'd9));         // after finish
    send_item(cmd_item(OP_SPARE));
    send_item(cmd_item(OP_FINISH));
    // piece ceiling
    send_item(slice_item(1'b1, 1'b1, 33'd0, 24'd1, 12'd0));
    d = 0;
    for (int i = 0; i < PIECE_CEIL + 2; i++) begin
      d += 33'd3;
      send_item(slice_item(1'($urandom), 1'b0, d, 24'($urandom_range(255)),
                           12'($urandom)));
    end
    send_item(cmd_item(OP_FINISH));
    drain();
  endtask

  task automatic random_stream(input int n);
    logic [32:0] d;
    int r;
    d = 33'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) send_item(cmd_item(OP_DISC));
      else if (r < 5) send_item(cmd_item(OP_FINISH));
      else if (r < 6) send_item(cmd_item(OP_SPARE));
      else if (r < 8) begin
        send_item(slice_item(1'($urandom), 1'($urandom), 33'({$urandom, $urandom}),
                             24'($urandom), 12'($urandom)));
      end else begin
        d += 33'($urandom_range(9000));
        send_item(slice_item(($urandom_range(9) != 0), ($urandom_range(5) == 0), d,
                             ($urandom_range(19) == 0) ? 24'($urandom) :
                             24'($urandom_range(4000)),
                             12'($urandom)));
      end
    end
  endtask

  task automatic test_config_and_random();
    random_stream(80);
    drain();
    write_reg(CFG_TARGET_MS, 40'd1);
    write_reg(CFG_MIN_MS, 40'd0);
    write_reg(CFG_MAX_MS, 40'd0);
    write_reg(CFG_SEG_BYTES, 40'd0);
    write_reg(CFG_WIN_COUNT, 40'd1);
    write_reg(CFG_WIN_BYTES, 40'd0);
    write_reg(CFG_SPARE, 40'hFF_FFFF_FFFF);                          // unused index
    random_stream(40);
    drain();
    idle_in_pct = 63;
    idle_out_pct = 13;
    write_reg(CFG_TARGET_MS, 40'hFF_FFFF);
    write_reg(CFG_MIN_MS, 40'hFF_FFFF);
    write_reg(CFG_MAX_MS, 40'hFF_FFFF);
    write_reg(CFG_SEG_BYTES, 40'hFFFF_FFFF);
    write_reg(CFG_WIN_COUNT, 40'd31);
    write_reg(CFG_WIN_BYTES, 40'hFF_FFFF_FFFF);
    random_stream(60);
    drain();
    idle_in_pct = 0;
    idle_out_pct = 0;
    write_reg(CFG_TARGET_MS, 40'd0);
    write_reg(CFG_MIN_MS, 40'd100);
    write_reg(CFG_MAX_MS, 40'd500);
    write_reg(CFG_SEG_BYTES, 40'd20000);
    write_reg(CFG_WIN_COUNT, 40'd0);
    write_reg(CFG_WIN_BYTES, 40'd30000);
    random_stream(40);
    drain();
    write_reg(CFG_TARGET_MS, 40'd2000);
    write_reg(CFG_MIN_MS, 40'd1000);
    write_reg(CFG_MAX_MS, 40'd3000);
    write_reg(CFG_SEG_BYTES, 40'd1000000);
    write_reg(CFG_WIN_COUNT, 40'd16);
    write_reg(CFG_WIN_BYTES, 40'd1);
    random_stream(40);
  endtask

  initial begin
    r_target = TARGET_MS_RST;
    r_min = MIN_MS_RST;
    r_max = MAX_MS_RST;
    r_seg_bytes = SEG_BYTES_RST;
    r_win_count = WIN_COUNT_RST;
    r_win_bytes = WIN_BYTES_RST;
    seg_open = 1'b0;
    disc_mark = 1'b0;
    seg_start_dts = '0;
    seg_end_dts = '0;
    pieces = 0;
    seg_bytes = '0;
    seq_next = '0;
    disc_total = '0;
    head = 0;
    count = 0;
    kept = '0;
    idle_in_pct = 13;
    idle_out_pct = 63;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_and_random();
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
